@@ hw/rtl/alec_pkg.sv @@
// ---------------------------------------------------------------------------
// alec_pkg: shared definitions for the alternating LED crossfade color block
// Q16 constants, register indexes and the packed color layout.
// ---------------------------------------------------------------------------
`default_nettype none

package alec_pkg;

	localparam int unsigned PROG_W    = 18;  // signed Q16 progress
	localparam int unsigned BLEND_W   = 17;  // blend factor 0..65536
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [16:0] Q_ONE        = 17'd65536;
	localparam logic [16:0] Q_HALF       = 17'd32768;
	localparam int unsigned FADE_PERCENT = 20;
	localparam int unsigned FADE_MUL     = 100 / FADE_PERCENT;
	localparam int unsigned FADE_HOLD    = (100 - FADE_PERCENT) / FADE_PERCENT;
	localparam logic [18:0] FADE_OFS     = 19'(65536 * FADE_HOLD);
	localparam logic [7:0]  FULL_SCALE   = 8'd255;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [BLEND_W-1:0] blend_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIMARY   = 2'd0,
		REG_SECONDARY = 2'd1,
		REG_SEC_EN    = 2'd2,
		REG_BRIGHT    = 2'd3
	} cfg_reg_t;

	// Channel k of a packed color: 0 red, 1 green, 2 blue.
	function automatic chan_t color_chan(input color_t c, input int unsigned k);
		chan_t r;
		r = c[(COLOR_W - CHAN_W * (k + 1)) +: CHAN_W];
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/alec_front.sv @@
// ---------------------------------------------------------------------------
// alec_front: progress clamp, phase and blend factor (stage 1)
// Clamps signed Q16 progress to 0..1 and derives the phase and the Q16 blend.
// ---------------------------------------------------------------------------
`default_nettype none

module alec_front (
	input  wire logic                           clk,
	input  wire logic [alec_pkg::PROG_W-1:0]    progress,
	output logic                                phase_s1,
	output alec_pkg::blend_t                    blend_s1
);
	import alec_pkg::*;

	logic [16:0] p;
	logic        phase;
	logic [15:0] sp;
	logic [16:0] s;
	logic [18:0] s5;
	blend_t      blend;

	always_comb begin
		if (progress[PROG_W-1]) begin
			p = '0;
		end else if (progress[PROG_W-2:0] > Q_ONE) begin
			p = Q_ONE;
		end else begin
			p = progress[16:0];
		end
		phase = (p >= Q_HALF);
		sp    = phase ? 16'(p - Q_HALF) : p[15:0];
		s     = {sp, 1'b0};
		s5    = ({2'b00, s} << 2) + {2'b00, s};
		// The fade only runs over the last part of each phase.
		if (s5 > FADE_OFS) begin
			blend = BLEND_W'(s5 - FADE_OFS);
		end else begin
			blend = '0;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase;
		blend_s1 <= blend;
	end

endmodule

`default_nettype wire

@@ hw/rtl/alec_blend_ch.sv @@
// ---------------------------------------------------------------------------
// alec_blend_ch: one channel of the crossfade (stage 2)
// Computes from + floor((to - from) * blend / 65536).
// ---------------------------------------------------------------------------
`default_nettype none

module alec_blend_ch (
	input  wire logic             clk,
	input  wire alec_pkg::chan_t  from_ch,
	input  wire alec_pkg::chan_t  to_ch,
	input  wire alec_pkg::blend_t blend,
	output alec_pkg::chan_t       ch_s2
);
	import alec_pkg::*;

	logic signed [8:0]  diff;
	logic signed [25:0] prod;
	logic [9:0]         sum;

	always_comb begin
		diff = $signed({1'b0, to_ch}) - $signed({1'b0, from_ch});
		prod = diff * $signed({1'b0, blend[15:0]});
		// The arithmetic shift gives the floor towards minus infinity.
		sum  = {2'b00, from_ch} + 10'(prod >>> 16);
	end

	always_ff @(posedge clk) begin
		if (blend[BLEND_W-1]) begin
			ch_s2 <= to_ch;
		end else begin
			ch_s2 <= sum[7:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/alec_scale_ch.sv @@
// ---------------------------------------------------------------------------
// alec_scale_ch: brightness scaling of one channel (stages 3 and 4)
// Multiplies by brightness, then divides by 255 with truncation.
// ---------------------------------------------------------------------------
`default_nettype none

module alec_scale_ch (
	input  wire logic             clk,
	input  wire alec_pkg::chan_t  ch,
	input  wire alec_pkg::chan_t  bright,
	output alec_pkg::chan_t       ch_s4
);
	import alec_pkg::*;

	logic [15:0] prod_s3;
	logic [16:0] quo;

	always_ff @(posedge clk) begin
		prod_s3 <= ch * bright;
	end

	// Exact floor(x / 255) for any x up to 65025, the largest product of two channels.
	always_comb begin
		quo = {1'b0, prod_s3} + 17'(prod_s3 >> 8) + 17'd1;
	end

	always_ff @(posedge clk) begin
		ch_s4 <= quo[15:8];
	end

endmodule

`default_nettype wire

@@ hw/rtl/alternating_led_crossfade_color_top.sv @@
// The start transfer reaches the done strobe through the stage valid registers valid_s1 to valid_s4.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Four register stages: clamp and blend factor, channel blend multiply,
// brightness multiply, divide by 255 into the output registers.
// Reset clears the stage valid bits and loads the register defaults
// (colors black, secondary disabled, brightness 255).
// ---------------------------------------------------------------------------
// alternating_led_crossfade_color_top: odd/even group crossfade colors
// Configuration registers, stage valid pipeline, phase routing and lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module alternating_led_crossfade_color_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [alec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [alec_pkg::COLOR_W-1:0]    cfg_wdata,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [alec_pkg::PROG_W-1:0]     progress,
	output logic                                 done,
	output logic [7:0]                           odd_red,
	output logic [7:0]                           odd_green,
	output logic [7:0]                           odd_blue,
	output logic [7:0]                           even_red,
	output logic [7:0]                           even_green,
	output logic [7:0]                           even_blue,
	output logic                                 phase
);
	import alec_pkg::*;

	color_t primary_q;
	color_t secondary_q;
	logic   sec_en_q;
	chan_t  bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q   <= '0;
			secondary_q <= '0;
			sec_en_q    <= 1'b0;
			bright_q    <= FULL_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRIMARY:   primary_q   <= cfg_wdata;
				REG_SECONDARY: secondary_q <= cfg_wdata;
				REG_SEC_EN:    sec_en_q    <= cfg_wdata[0];
				REG_BRIGHT:    bright_q    <= cfg_wdata[CHAN_W-1:0];
				default:       ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic phase_s1, phase_s2, phase_s3, phase_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		phase_s2 <= phase_s1;
		phase_s3 <= phase_s2;
		phase_s4 <= phase_s3;
	end

	blend_t blend_s1;

	alec_front u_front (
		.clk      (clk),
		.progress (progress),
		.phase_s1 (phase_s1),
		.blend_s1 (blend_s1)
	);

	color_t sec_color;
	color_t odd_from, odd_to, even_from, even_to;

	// Phase 0 fades odd from primary to secondary, even the other way round.
	always_comb begin
		sec_color = sec_en_q ? secondary_q : '0;
		if (phase_s1) begin
			odd_from  = sec_color;
			odd_to    = primary_q;
			even_from = primary_q;
			even_to   = sec_color;
		end else begin
			odd_from  = primary_q;
			odd_to    = sec_color;
			even_from = sec_color;
			even_to   = primary_q;
		end
	end

	chan_t lane_s2 [6];
	chan_t lane_s4 [6];

	for (genvar k = 0; k < 3; k++) begin : g_lane
		alec_blend_ch u_blend_odd (
			.clk     (clk),
			.from_ch (color_chan(odd_from, k)),
			.to_ch   (color_chan(odd_to, k)),
			.blend   (blend_s1),
			.ch_s2   (lane_s2[k])
		);
		alec_blend_ch u_blend_even (
			.clk     (clk),
			.from_ch (color_chan(even_from, k)),
			.to_ch   (color_chan(even_to, k)),
			.blend   (blend_s1),
			.ch_s2   (lane_s2[k+3])
		);
		alec_scale_ch u_scale_odd (
			.clk    (clk),
			.ch     (lane_s2[k]),
			.bright (bright_q),
			.ch_s4  (lane_s4[k])
		);
		alec_scale_ch u_scale_even (
			.clk    (clk),
			.ch     (lane_s2[k+3]),
			.bright (bright_q),
			.ch_s4  (lane_s4[k+3])
		);
	end

	assign done       = valid_s4;
	assign phase      = phase_s4;
	assign odd_red    = lane_s4[0];
	assign odd_green  = lane_s4[1];
	assign odd_blue   = lane_s4[2];
	assign even_red   = lane_s4[3];
	assign even_green = lane_s4[4];
	assign even_blue  = lane_s4[5];

endmodule

`default_nettype wire

@@ hw/rtl/alec_checker.sv @@
// ---------------------------------------------------------------------------
// alec_checker: port-level checks for the crossfade color block
// Done aligned with each transfer, no stall and phase derived from the progress.
// ---------------------------------------------------------------------------
`default_nettype none

module alec_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [17:0] progress,
	input  wire logic        done,
	input  wire logic        phase
);

	// The pipeline never holds off a start transfer.
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing four cycles after a transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##4 !done)
		else $error("result without a matching transfer");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4
		(phase == $past(!progress[17] && (progress[16] || progress[15]), 4)))
		else $error("phase does not match the progress");

endmodule

bind alternating_led_crossfade_color_top alec_checker u_alec_checker (.*);

`default_nettype wire
